FILE: rtl/gcd_pkg.sv
// ============================================================================
// gcd_pkg
// Shared types, constants and helpers for the great-circle distance pipeline.
// ============================================================================
`default_nettype none

package gcd_pkg;

    // Fraction bits of the incoming degree values.
    localparam int ANGLE_FRAC_BITS = 16;
    // Default number of CORDIC steps; the arctangent table has 32 entries.
    localparam int TRIG_ITERATIONS_DEF = 24;
    localparam int ATAN_ENTRIES = 32;

    // Datapath width of the CORDIC registers (Q30 values with headroom).
    localparam int CW = 34;
    // Width of the Q30 sine and cosine values after the sign fix.
    localparam int QW = 33;

    localparam logic signed [26:0] DEG_FULL    = 27'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [26:0] DEG_HALF    = 27'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [26:0] DEG_QUARTER = 27'(90 * (2 ** ANGLE_FRAC_BITS));

    // pi/180 in Q40, split for two narrow partial products.
    localparam logic [34:0] DEG_TO_RAD_Q40 = 35'd19190098069;
    localparam logic [16:0] DEG_TO_RAD_HI  = DEG_TO_RAD_Q40[34:18];
    localparam logic [17:0] DEG_TO_RAD_LO  = DEG_TO_RAD_Q40[17:0];

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [34:0]   Q30_ONE     = 35'sd1073741824;

    localparam logic [15:0] RADIUS_RESET = 16'd6371;

    // Arctangent of 2^-i in Q30.
    localparam logic [29:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001, 30'h00000000
    };

    // Angle folded into [-90, 90] degrees, with a flag to negate sin and cos.
    typedef struct packed {
        logic               flip;
        logic signed [23:0] ang;
    } t_fold;

    // Side information carried through the sine/cosine CORDIC.
    typedef struct packed {
        logic zero;
        logic flip_a;
        logic flip_b;
        logic flip_d;
    } t_rot_tag;

    // Side information carried through the square root.
    typedef struct packed {
        logic               zero;
        logic signed [31:0] cosv;
    } t_sqrt_tag;

    // Reduce an angle modulo 360 degrees into [-180, 180) and fold to [-90, 90].
    function automatic t_fold fold_angle(input logic signed [26:0] d);
        logic signed [26:0] r;
        t_fold              f;
        r = d;
        if (r >= DEG_FULL) begin
            r = r - DEG_FULL;
        end else if (r <= -DEG_FULL) begin
            r = r + DEG_FULL;
        end
        if (r >= DEG_HALF) begin
            r = r - DEG_FULL;
        end
        if (r < -DEG_HALF) begin
            r = r + DEG_FULL;
        end
        f.flip = 1'b0;
        if (r > DEG_QUARTER) begin
            r = r - DEG_HALF;
            f.flip = 1'b1;
        end else if (r < -DEG_QUARTER) begin
            r = r + DEG_HALF;
            f.flip = 1'b1;
        end
        f.ang = r[23:0];
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gcd_cordic.sv
// ============================================================================
// gcd_cordic
// Pipelined CORDIC, one step per register stage, rotation or vectoring mode.
// ============================================================================
`default_nettype none

module gcd_cordic
    import gcd_pkg::*;
#(
    parameter int ITER   = TRIG_ITERATIONS_DEF,
    parameter bit VECTOR = 1'b0,
    parameter int TAG_W  = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [CW-1:0] i_z,
    input  wire logic [TAG_W-1:0]     i_tag,
    output logic                      o_valid,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic signed [CW-1:0]      o_z,
    output logic [TAG_W-1:0]          o_tag
);

    for (genvar k = 0; k < ITER; k++) begin : g_step
        logic                 r_v;
        logic signed [CW-1:0] r_x, r_y, r_z;
        logic [TAG_W-1:0]     r_t;
        logic                 a_v;
        logic signed [CW-1:0] a_x, a_y, a_z, dx, dy, at;
        logic [TAG_W-1:0]     a_t;
        logic                 dir;

        // Stage input comes from the ports or from the previous step.
        if (k == 0) begin : g_first
            assign a_v = i_valid;
            assign a_x = i_x;
            assign a_y = i_y;
            assign a_z = i_z;
            assign a_t = i_tag;
        end else begin : g_next
            assign a_v = g_step[k-1].r_v;
            assign a_x = g_step[k-1].r_x;
            assign a_y = g_step[k-1].r_y;
            assign a_z = g_step[k-1].r_z;
            assign a_t = g_step[k-1].r_t;
        end

        assign dx  = a_y >>> k;
        assign dy  = a_x >>> k;
        assign at  = $signed({{(CW-30){1'b0}}, ATAN_Q30[k]});
        // Rotation steers on the residual angle, vectoring on the y sign.
        assign dir = VECTOR ? ~a_y[CW-1] : ~a_z[CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= a_v;
            end
        end

        // One micro-rotation.
        always_ff @(posedge i_clk) begin
            r_t <= a_t;
            if (dir ^ VECTOR) begin
                r_x <= a_x - dx;
                r_y <= a_y + dy;
                r_z <= a_z - at;
            end else begin
                r_x <= a_x + dx;
                r_y <= a_y - dy;
                r_z <= a_z + at;
            end
        end
    end

    assign o_valid = g_step[ITER-1].r_v;
    assign o_x     = g_step[ITER-1].r_x;
    assign o_y     = g_step[ITER-1].r_y;
    assign o_z     = g_step[ITER-1].r_z;
    assign o_tag   = g_step[ITER-1].r_t;

endmodule

`default_nettype wire

FILE: rtl/gcd_isqrt.sv
// ============================================================================
// gcd_isqrt
// Pipelined floor integer square root, one result bit per register stage.
// ============================================================================
`default_nettype none

module gcd_isqrt
    import gcd_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [61:0]      i_n,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [31:0]           o_root,
    output logic [TAG_W-1:0]      o_tag
);

    // Operand stays below 2^61, so the test bit starts at 2^60.
    localparam int STEPS = 31;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
        logic             r_v;
        logic [61:0]      r_n, r_root;
        logic [TAG_W-1:0] r_t;
        logic             a_v;
        logic [61:0]      a_n, a_root, trial;
        logic [TAG_W-1:0] a_t;

        if (k == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_n    = i_n;
            assign a_root = '0;
            assign a_t    = i_tag;
        end else begin : g_next
            assign a_v    = g_step[k-1].r_v;
            assign a_n    = g_step[k-1].r_n;
            assign a_root = g_step[k-1].r_root;
            assign a_t    = g_step[k-1].r_t;
        end

        assign trial = a_root + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= a_v;
            end
        end

        // Keep the bit when the remainder allows it.
        always_ff @(posedge i_clk) begin
            r_t <= a_t;
            if (a_n >= trial) begin
                r_n    <= a_n - trial;
                r_root <= (a_root >> 1) + BIT;
            end else begin
                r_n    <= a_n;
                r_root <= a_root >> 1;
            end
        end
    end

    assign o_valid = g_step[STEPS-1].r_v;
    assign o_root  = g_step[STEPS-1].r_root[31:0];
    assign o_tag   = g_step[STEPS-1].r_t;

endmodule

`default_nettype wire

FILE: rtl/great_circle_distance_unit.sv
// ============================================================================
// great_circle_distance_unit
// Great-circle distance by the spherical law of cosines, fully pipelined.
// ============================================================================
//
// Channel   Direction  Handshake                      Payload
// -------   ---------  -----------------------------  --------------------------
// request   in         start & !busy                  first/second lat and lon
// result    out        o_done strobe, one cycle       o_arc_distance (1/256 km)
// config    in         APB write, psel&penable&pwrite  radius at addresses 0 to 3
//
// One item is taken in every cycle; busy is always low.
// The path holds two N-step CORDIC pipelines with N = min(TRIG_ITERATIONS, 32)
// and a 31-stage square root.
// Reset clears only the valid bits and the radius register.
// The receiver cannot stall, so the pipeline never holds.
// ============================================================================
`default_nettype none

module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] i_first_lat,
    input  wire logic signed [24:0] i_first_lon,
    input  wire logic signed [23:0] i_second_lat,
    input  wire logic signed [24:0] i_second_lon,
    output logic                    o_done,
    output logic [25:0]             o_arc_distance,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int N = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;

    // Configuration register.
    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_radius <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_radius};
    assign busy   = 1'b0;

    // Stage 0: capture the item, longitude difference and the same-point flag.
    logic                r0_v;
    logic                r0_zero;
    logic signed [26:0]  r0_ang [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_zero   <= (i_first_lat == i_second_lat) && (i_first_lon == i_second_lon);
        r0_ang[0] <= 27'(i_first_lat);
        r0_ang[1] <= 27'(i_second_lat);
        r0_ang[2] <= 27'(i_second_lon) - 27'(i_first_lon);
    end

    // Stage 1: reduce and fold each angle.
    logic  r1_v;
    logic  r1_zero;
    t_fold r1_f [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero <= r0_zero;
        for (int j = 0; j < 3; j++) begin
            r1_f[j] <= fold_angle(r0_ang[j]);
        end
    end

    // Stage 2: partial products of degrees to radians.
    logic        r2_v;
    logic        r2_zero;
    logic        r2_flip [0:2];
    logic        r2_neg  [0:2];
    logic [39:0] r2_phi  [0:2];
    logic [40:0] r2_plo  [0:2];
    logic [22:0] mag     [0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mag[j] = r1_f[j].ang[23] ? 23'(-r1_f[j].ang) : r1_f[j].ang[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zero <= r1_zero;
        for (int j = 0; j < 3; j++) begin
            r2_flip[j] <= r1_f[j].flip;
            r2_neg[j]  <= r1_f[j].ang[23];
            r2_phi[j]  <= 40'(mag[j]) * 40'(DEG_TO_RAD_HI);
            r2_plo[j]  <= 41'(mag[j]) * 41'(DEG_TO_RAD_LO);
        end
    end

    // Stage 3: round the radian angle and restore its sign.
    logic                 r3_v;
    t_rot_tag             r3_tag;
    logic signed [CW-1:0] r3_z [0:2];
    logic [58:0]          psum [0:2];
    logic [CW-1:0]        pmag [0:2];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            psum[j] = {1'b0, r2_phi[j], 18'd0} + 59'(r2_plo[j]) + (59'(1) << 25);
            pmag[j] = CW'(psum[j] >> 26);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_tag <= '{zero: r2_zero, flip_a: r2_flip[0], flip_b: r2_flip[1],
                    flip_d: r2_flip[2]};
        for (int j = 0; j < 3; j++) begin
            r3_z[j] <= r2_neg[j] ? -$signed(pmag[j]) : $signed(pmag[j]);
        end
    end

    // Sine and cosine of the three angles.
    logic                 rot_v;
    logic [3:0]           rot_tag_bits;
    t_rot_tag             rot_tag;
    logic signed [CW-1:0] rot_x [0:2];
    logic signed [CW-1:0] rot_y [0:2];

    gcd_cordic #(.ITER(N), .VECTOR(1'b0), .TAG_W($bits(t_rot_tag))) u_rot_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_x     (CORDIC_GAIN),
        .i_y     ('0),
        .i_z     (r3_z[0]),
        .i_tag   (r3_tag),
        .o_valid (rot_v),
        .o_x     (rot_x[0]),
        .o_y     (rot_y[0]),
        .o_z     (),
        .o_tag   (rot_tag_bits)
    );

    for (genvar j = 1; j < 3; j++) begin : g_rot
        gcd_cordic #(.ITER(N), .VECTOR(1'b0), .TAG_W(1)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r3_v),
            .i_x     (CORDIC_GAIN),
            .i_y     ('0),
            .i_z     (r3_z[j]),
            .i_tag   (1'b0),
            .o_valid (),
            .o_x     (rot_x[j]),
            .o_y     (rot_y[j]),
            .o_z     (),
            .o_tag   ()
        );
    end

    assign rot_tag = t_rot_tag'(rot_tag_bits);

    // Stage 4: apply the quadrant sign fix.
    logic                 r4_v;
    logic                 r4_zero;
    logic signed [QW-1:0] r4_s1, r4_c1, r4_s2, r4_c2, r4_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= rot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_zero <= rot_tag.zero;
        r4_s1   <= QW'(rot_tag.flip_a ? -rot_y[0] : rot_y[0]);
        r4_c1   <= QW'(rot_tag.flip_a ? -rot_x[0] : rot_x[0]);
        r4_s2   <= QW'(rot_tag.flip_b ? -rot_y[1] : rot_y[1]);
        r4_c2   <= QW'(rot_tag.flip_b ? -rot_x[1] : rot_x[1]);
        r4_cd   <= QW'(rot_tag.flip_d ? -rot_x[2] : rot_x[2]);
    end

    // Stage 5: first products.
    logic                   r5_v;
    logic                   r5_zero;
    logic signed [2*QW-1:0] r5_pss, r5_pcc;
    logic signed [QW-1:0]   r5_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_zero <= r4_zero;
        r5_pss  <= r4_s1 * r4_s2;
        r5_pcc  <= r4_c1 * r4_c2;
        r5_cd   <= r4_cd;
    end

    // Stage 6: round both products to Q30.
    localparam logic signed [2*QW-1:0] RND30 = (2*QW)'(1) << 29;

    logic                   r6_v;
    logic                   r6_zero;
    logic signed [QW-1:0]   r6_ss, r6_cc, r6_cd;
    logic signed [2*QW-1:0] rss_w, rcc_w;

    assign rss_w = (r5_pss + RND30) >>> 30;
    assign rcc_w = (r5_pcc + RND30) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_zero <= r5_zero;
        r6_ss   <= QW'(rss_w);
        r6_cc   <= QW'(rcc_w);
        r6_cd   <= r5_cd;
    end

    // Stage 7: product with the cosine of the longitude difference.
    logic                   r7_v;
    logic                   r7_zero;
    logic signed [2*QW-1:0] r7_p;
    logic signed [QW-1:0]   r7_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_zero <= r6_zero;
        r7_p    <= r6_cc * r6_cd;
        r7_ss   <= r6_ss;
    end

    // Stage 8: round, add and clamp the cosine sum to [-1, 1].
    logic                   r8_v;
    logic                   r8_zero;
    logic signed [31:0]     r8_c;
    logic signed [2*QW-1:0] rp_w;
    logic signed [34:0]     sum_w;

    assign rp_w  = (r7_p + RND30) >>> 30;
    assign sum_w = 35'(r7_ss) + 35'($signed(rp_w[QW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_zero <= r7_zero;
        if (sum_w > Q30_ONE) begin
            r8_c <= 32'(Q30_ONE);
        end else if (sum_w < -Q30_ONE) begin
            r8_c <= 32'(-Q30_ONE);
        end else begin
            r8_c <= 32'(sum_w);
        end
    end

    // Stage 9: square of the cosine.
    logic               r9_v;
    logic               r9_zero;
    logic signed [61:0] r9_cc;
    logic signed [31:0] r9_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_zero <= r8_zero;
        r9_cc   <= r8_c * r8_c;
        r9_c    <= r8_c;
    end

    // Stage 10: one minus the square, the operand of the sine root.
    logic        r10_v;
    t_sqrt_tag   r10_tag;
    logic [61:0] r10_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_tag <= '{zero: r9_zero, cosv: r9_c};
        r10_n   <= (62'(1) << 60) - $unsigned(r9_cc);
    end

    // Sine of the central angle.
    logic                          sq_v;
    logic [31:0]                   sq_root;
    logic [$bits(t_sqrt_tag)-1:0]  sq_tag_bits;
    t_sqrt_tag                     sq_tag;

    gcd_isqrt #(.TAG_W($bits(t_sqrt_tag))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r10_v),
        .i_n     (r10_n),
        .i_tag   (r10_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag_bits)
    );

    assign sq_tag = t_sqrt_tag'(sq_tag_bits);

    // Stage 11: start vector, turned a quarter when the cosine is negative.
    logic                 r11_v;
    logic                 r11_zero;
    logic signed [CW-1:0] r11_x, r11_y, r11_z;
    logic signed [CW-1:0] cx_w, sy_w;

    assign cx_w = CW'(sq_tag.cosv);
    assign sy_w = $signed({2'b00, sq_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r11_zero <= sq_tag.zero;
        if (cx_w < 0) begin
            r11_x <= sy_w;
            r11_y <= -cx_w;
            r11_z <= HALF_PI_Q30;
        end else begin
            r11_x <= cx_w;
            r11_y <= sy_w;
            r11_z <= '0;
        end
    end

    // Arc cosine by vectoring.
    logic                 vec_v;
    logic                 vec_zero;
    logic signed [CW-1:0] vec_z;

    gcd_cordic #(.ITER(N), .VECTOR(1'b1), .TAG_W(1)) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_v),
        .i_x     (r11_x),
        .i_y     (r11_y),
        .i_z     (r11_z),
        .i_tag   (r11_zero),
        .o_valid (vec_v),
        .o_x     (),
        .o_y     (),
        .o_z     (vec_z),
        .o_tag   (vec_zero)
    );

    // Stage 12: clamp the angle to [0, pi].
    logic        r12_v;
    logic        r12_zero;
    logic [31:0] r12_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else begin
            r12_v <= vec_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r12_zero <= vec_zero;
        if (vec_z < 0) begin
            r12_ang <= '0;
        end else if (vec_z > PI_Q30) begin
            r12_ang <= PI_Q30[31:0];
        end else begin
            r12_ang <= vec_z[31:0];
        end
    end

    // Stage 13: scale by the radius.
    logic        r13_v;
    logic        r13_zero;
    logic [47:0] r13_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_v <= 1'b0;
        end else begin
            r13_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r13_zero <= r12_zero;
        r13_prod <= 48'(r12_ang) * 48'(r_radius);
    end

    // Stage 14: round to 1/256 km and present the result item.
    logic [47:0] dist_w;

    assign dist_w = (r13_prod + (48'(1) << 21)) >> 22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r13_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_arc_distance <= r13_zero ? 26'd0 : dist_w[25:0];
    end

endmodule

`default_nettype wire

FILE: test/great_circle_distance_unit_tb.sv
// ============================================================================
// great_circle_distance_unit_tb
// Checks the great-circle distance unit against a bit-exact fixed-point model.
// Point pairs are sent in random bursts across several sphere radius settings.
// Every distance is compared in order with the one the model predicts.
// ============================================================================
`timescale 1ns / 1ps

module great_circle_distance_unit_tb
    import gcd_pkg::*;
();

    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int STEPS = (TRIG_ITERATIONS_DEF < 32) ? TRIG_ITERATIONS_DEF : 32;
    localparam int PIPE_DEPTH = 2 * STEPS + 46;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] RADIUS_ADDR = 3'd0;
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    // Distance model and the queue of distances still to come out.
    class distance_scoreboard;
        bit [15:0] radius_km;
        bit [25:0] expected_distances[$];
        int        errors;

        function new();
            radius_km = RADIUS_RESET;
            errors    = 0;
        endfunction

        function longint q30_mul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        // Degrees with 16 fraction bits to Q30 radians, rounded away from zero.
        function longint to_radians(longint r);
            longint unsigned m;
            longint unsigned p;
            m = (r < 0) ? -r : r;
            p = (m * longint'(DEG_TO_RAD_Q40) + (64'd1 << (ANGLE_FRAC_BITS + 9)))
                >> (ANGLE_FRAC_BITS + 10);
            return (r < 0) ? -longint'(p) : longint'(p);
        endfunction

        // Rotation CORDIC after reducing the angle to [-90, 90] degrees.
        function void sine_cosine(longint deg, output longint sn, output longint cs);
            longint full_turn;
            longint half_turn;
            longint quarter_turn;
            longint r;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit     flip;
            full_turn    = longint'(360) << ANGLE_FRAC_BITS;
            half_turn    = longint'(180) << ANGLE_FRAC_BITS;
            quarter_turn = longint'(90) << ANGLE_FRAC_BITS;
            r    = deg % full_turn;
            flip = 1'b0;
            if (r >= half_turn) r -= full_turn;
            if (r < -half_turn) r += full_turn;
            if (r > quarter_turn) begin
                r -= half_turn;
                flip = 1'b1;
            end else if (r < -quarter_turn) begin
                r += half_turn;
                flip = 1'b1;
            end
            z = to_radians(r);
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ATAN_Q30[i]);
                end else begin
                    x += dx;
                    y -= dy;
                    z += longint'(ATAN_Q30[i]);
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b    = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= root + b) begin
                    n -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        // Vectoring CORDIC on (c, sqrt(1 - c^2)) gives the angle in [0, pi].
        function longint arc_cosine(longint c);
            longint x;
            longint y;
            longint z;
            longint t;
            longint dx;
            longint dy;
            x = c;
            y = longint'(floor_sqrt((64'd1 << 60) - longint'(c * c)));
            z = 0;
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = longint'(HALF_PI_Q30);
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                    z += longint'(ATAN_Q30[i]);
                end else begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ATAN_Q30[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
            return z;
        endfunction

        function void note_pair(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                                logic signed [23:0] lat_b, logic signed [24:0] lon_b);
            longint s1, c1, s2, c2, sd, cd, sum, angle;
            longint unsigned span;
            if (lat_a == lat_b && lon_a == lon_b) begin
                expected_distances.push_back('0);
                return;
            end
            sine_cosine(longint'(lat_a), s1, c1);
            sine_cosine(longint'(lat_b), s2, c2);
            sine_cosine(longint'(lon_b) - longint'(lon_a), sd, cd);
            sum = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
            if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
            if (sum < -longint'(Q30_ONE)) sum = -longint'(Q30_ONE);
            angle = arc_cosine(sum);
            span = (longint'(angle) * longint'(radius_km) + (64'd1 << 21)) >> 22;
            expected_distances.push_back(span[25:0]);
        endfunction

        function void check_distance(bit [25:0] actual);
            bit [25:0] want;
            if (expected_distances.size() == 0) begin
                $error("arc_distance: unexpected result %0d", actual);
                errors++;
                return;
            end
            want = expected_distances.pop_front();
            if (want !== actual) begin
                $error("arc_distance: expected %0d, got %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [23:0] i_first_lat = '0;
    logic signed [24:0] i_first_lon = '0;
    logic signed [23:0] i_second_lat = '0;
    logic signed [24:0] i_second_lon = '0;
    logic               o_done;
    logic [25:0]        o_arc_distance;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    distance_scoreboard distances = new();
    int stall_cycles = 0;
    bit progress = 1'b0;

    great_circle_distance_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_lat    (i_first_lat),
        .i_first_lon    (i_first_lon),
        .i_second_lat   (i_second_lat),
        .i_second_lon   (i_second_lon),
        .o_done         (o_done),
        .o_arc_distance (o_arc_distance),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    // Results are checked as they leave the pipeline.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            distances.check_distance(o_arc_distance);
            progress = 1'b1;
        end
    end

    // The run ends if nothing moves for too long.
    always @(posedge i_clk) begin
        #1;
        if (progress) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        progress = 1'b0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("great_circle_distance_unit_tb: done, errors");
            $finish;
        end
    end

    // One point pair; start stays high if the next item follows at once.
    task automatic send_pair(logic signed [23:0] lat_a, logic signed [24:0] lon_a,
                             logic signed [23:0] lat_b, logic signed [24:0] lon_b);
        @(negedge i_clk);
        i_first_lat  = lat_a;
        i_first_lon  = lon_a;
        i_second_lat = lat_b;
        i_second_lon = lon_b;
        start        = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        distances.note_pair(lat_a, lon_a, lat_b, lon_b);
        progress = 1'b1;
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Two-phase register access; a write to the radius also updates the model.
    task automatic reg_access(logic write, logic [2:0] addr, logic [31:0] data,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        rdata = prdata;
        progress = 1'b1;
        if (write && addr == RADIUS_ADDR) distances.radius_km = data[15:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_radius(logic [15:0] km);
        logic [31:0] rd;
        reg_access(1'b1, RADIUS_ADDR, {16'h0, km}, rd);
        reg_access(1'b0, RADIUS_ADDR, '0, rd);
        if (rd[15:0] !== km) begin
            $error("sphere_radius_km: expected %0d, got %0d", km, rd[15:0]);
            distances.errors++;
        end
    endtask

    // Waits until every distance is out, then lets the pipeline empty.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (distances.expected_distances.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_lat();
        return 24'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [24:0] rand_lon();
        return 25'($signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
    endfunction

    // Random pairs in bursts: mostly in range, some close or identical points,
    // and a few raw bit patterns that fall outside the usual ranges.
    task automatic random_burst(int count);
        logic signed [23:0] la, lb;
        logic signed [24:0] oa, ob;
        int kind;
        int left;
        int run;
        left = count;
        while (left > 0) begin
            run = $urandom_range(1, 40);
            for (int k = 0; k < run && left > 0; k++) begin
                kind = $urandom_range(0, 99);
                la = rand_lat();
                oa = rand_lon();
                lb = rand_lat();
                ob = rand_lon();
                if (kind < 10) begin
                    lb = la + 24'($signed($urandom_range(0, 64)) - 32);
                    ob = oa + 25'($signed($urandom_range(0, 64)) - 32);
                end else if (kind < 15) begin
                    lb = la;
                    ob = oa;
                end else if (kind < 22) begin
                    la = 24'($urandom());
                    oa = 25'($urandom());
                    lb = 24'($urandom());
                    ob = 25'($urandom());
                end
                send_pair(la, oa, lb, ob);
                left--;
            end
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
        end
    endtask

    initial begin
        logic [31:0] rd;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset radius, then an unused register that must be ignored.
        reg_access(1'b0, RADIUS_ADDR, '0, rd);
        if (rd[15:0] !== RADIUS_RESET) begin
            $error("sphere_radius_km: expected %0d, got %0d", RADIUS_RESET, rd[15:0]);
            distances.errors++;
        end
        reg_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF, rd);

        // Directed pairs: poles, date line, antipodes, identical points.
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, 0);
        send_pair(LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
        send_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 1, 0);
        send_pair(2949120, 5898240, -2949120, -5898240);
        send_pair(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
        send_pair(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
        send_pair(24'sh7FFFFF, 25'sh1000000, 24'sh7FFFFF, 25'sh1000000);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(LAT_MAX - 1, 12345, LAT_MAX, -12345);
        send_pair(-1, -1, 1, 1);
        drain();

        random_burst(200);
        drain();
        set_radius(16'd0);
        random_burst(150);
        drain();
        set_radius(16'hFFFF);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        random_burst(200);
        drain();
        set_radius(16'd1);
        random_burst(150);
        drain();
        set_radius(16'($urandom()));
        random_burst(150);
        drain();
        set_radius(16'd6371);
        random_burst(150);
        drain();

        if (distances.errors == 0) begin
            $display("great_circle_distance_unit_tb: done, clean");
        end else begin
            $display("great_circle_distance_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gcd_pkg.sv
rtl/gcd_cordic.sv
rtl/gcd_isqrt.sv
rtl/great_circle_distance_unit.sv
test/great_circle_distance_unit_tb.sv
